>>> design/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg: shared types and constants for interval sort and merge
// Store geometry, field widths, sequencer states and the store write port.
// ----------------------------------------------------------------------------
`default_nettype none

package ism_pkg;

    localparam int MAX_INTERVALS = 64;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int MS_W          = 31;

    typedef logic [MS_W-1:0]  ms_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Store write port
    typedef struct packed {
        logic we;
        idx_t addr;
        ms_t  beg_ms;
        ms_t  fin_ms;
    } store_wr_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_RDI,
        S_SORT_LDI,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SWAP_RD,
        S_SWAP_WR1,
        S_SWAP_WR2,
        S_NEXT_I,
        S_MRG_RD0,
        S_MRG_LD0,
        S_MRG_RD,
        S_MRG_OVL,
        S_MRG_EXT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> design/ism_store.sv
// ----------------------------------------------------------------------------
// ism_store: interval store
// Begin and end memories sharing one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_store (
    input  wire logic              clk,
    input  wire ism_pkg::store_wr_t wr,
    input  wire ism_pkg::idx_t     raddr,
    output ism_pkg::ms_t           rd_beg,
    output ism_pkg::ms_t           rd_fin
);

    ism_pkg::ms_t beg_mem [ism_pkg::MAX_INTERVALS];
    ism_pkg::ms_t fin_mem [ism_pkg::MAX_INTERVALS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            beg_mem[wr.addr] <= wr.beg_ms;
            fin_mem[wr.addr] <= wr.fin_ms;
        end
        rd_beg <= beg_mem[raddr];
        rd_fin <= fin_mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/ism_cmp.sv
// ----------------------------------------------------------------------------
// ism_cmp: shared magnitude comparator
// Unsigned a < b, used by both the sort scan and the merge walk.
// ----------------------------------------------------------------------------
`default_nettype none

module ism_cmp (
    input  wire ism_pkg::ms_t a,
    input  wire ism_pkg::ms_t b,
    output logic              lt
);

    assign lt = (a < b);

endmodule

`default_nettype wire

>>> design/interval_sort_and_merge.sv
// ----------------------------------------------------------------------------
// interval_sort_and_merge: collect, sort and merge time intervals
// Loads intervals, selection-sorts them by begin, merges overlapping ones.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one interval per transfer, begin_ms,
//   end_ms and last_item. While loading, in_ready is high and one interval
//   is taken per cycle. Up to MAX_INTERVALS (64) are held; further ones are
//   dropped and reported on dropped_flag of every result of that set.
//   The transfer carrying last_item starts the sort; in_ready stays low until
//   the final merged interval has been loaded into the output register.
//   Sort: selection sort over the held n intervals with one shared comparator;
//   each position is read, the rest are scanned for the smallest begin, and
//   a swap follows if one is found; skipped for n = 1. Merge: each interval
//   is read and checked for overlap, and the running interval is extended or emitted.
//   Output channel (out_valid/out_ready): merged intervals in ascending begin
//   order, last_result on the final one. A single output register holds a
//   result; when the receiver stalls, the merge walk waits in its emit step.
//   Reset empties the store count and clears the overflow flag and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_sort_and_merge (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire ism_pkg::ms_t begin_ms,
    input  wire ism_pkg::ms_t end_ms,
    input  wire logic         last_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output ism_pkg::ms_t      merged_begin_ms,
    output ism_pkg::ms_t      merged_end_ms,
    output logic              last_result,
    output logic              dropped_flag
);

    // ------------------------------------------------------------------
    // State and datapath registers
    // ------------------------------------------------------------------
    ism_pkg::state_t state_reg, state_next;
    ism_pkg::cnt_t   count_reg, count_next;     // held intervals (n)
    logic            ovf_reg, ovf_next;
    logic            out_valid_reg, out_valid_next;

    ism_pkg::idx_t   i_reg, i_next;             // sort position
    ism_pkg::idx_t   j_reg, j_next;             // scan index
    ism_pkg::idx_t   pick_idx_reg, pick_idx_next;
    ism_pkg::ms_t    pick_b_reg, pick_b_next;
    ism_pkg::ms_t    start_i_reg, start_i_next;
    ism_pkg::ms_t    fin_i_reg, fin_i_next;
    ism_pkg::ms_t    fin_pick_reg, fin_pick_next;

    ism_pkg::idx_t   k_reg, k_next;             // merge walk index
    ism_pkg::ms_t    cur_b_reg, cur_b_next;     // running merged interval
    ism_pkg::ms_t    cur_e_reg, cur_e_next;
    ism_pkg::ms_t    nb_reg, nb_next;           // interval just read
    ism_pkg::ms_t    ne_reg, ne_next;
    logic            fin_flag_reg, fin_flag_next;

    ism_pkg::ms_t    out_b_reg, out_b_next;
    ism_pkg::ms_t    out_e_reg, out_e_next;
    logic            out_last_reg, out_last_next;
    logic            out_drop_reg, out_drop_next;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    ism_pkg::store_wr_t wr;
    ism_pkg::idx_t      raddr;
    ism_pkg::ms_t       rd_beg, rd_fin;
    ism_pkg::ms_t       cmp_a, cmp_b;
    logic               cmp_lt;

    ism_store u_store (
        .clk    (clk),
        .wr     (wr),
        .raddr  (raddr),
        .rd_beg (rd_beg),
        .rd_fin (rd_fin)
    );

    ism_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    // ------------------------------------------------------------------
    // Helper conditions
    // ------------------------------------------------------------------
    logic          in_xfer;
    logic          has_room;
    logic          out_free;
    ism_pkg::cnt_t cnt_after;
    logic          scan_more;     // j + 1 < n
    logic          sort_more;     // i + 2 < n
    logic          walk_more;     // k + 1 < n
    logic          scan_pick;

    assign in_xfer   = in_valid && in_ready;
    assign has_room  = (count_reg < ism_pkg::cnt_t'(ism_pkg::MAX_INTERVALS));
    assign cnt_after = has_room ? (count_reg + ism_pkg::cnt_t'(1)) : count_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_more = ({1'b0, j_reg} + ism_pkg::cnt_t'(1)) < count_reg;
    assign sort_more = ({1'b0, i_reg} + ism_pkg::cnt_t'(2)) < count_reg;
    assign walk_more = ({1'b0, k_reg} + ism_pkg::cnt_t'(1)) < count_reg;
    // set when the index that wins the scan step differs from i, accounting for this cycle's compare
    assign scan_pick = cmp_lt ? (j_reg != i_reg) : (pick_idx_reg != i_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ism_pkg::S_LOAD:
            begin
                if (in_xfer && last_item)
                begin
                    if (cnt_after >= ism_pkg::cnt_t'(2))
                        state_next = ism_pkg::S_SORT_RDI;
                    else
                        state_next = ism_pkg::S_MRG_RD0;
                end
            end
            ism_pkg::S_SORT_RDI: state_next = ism_pkg::S_SORT_LDI;
            ism_pkg::S_SORT_LDI: state_next = ism_pkg::S_SCAN_RD;
            ism_pkg::S_SCAN_RD:  state_next = ism_pkg::S_SCAN_CMP;
            ism_pkg::S_SCAN_CMP:
            begin
                if (scan_more)
                    state_next = ism_pkg::S_SCAN_RD;
                else if (scan_pick)
                    state_next = ism_pkg::S_SWAP_RD;
                else
                    state_next = ism_pkg::S_NEXT_I;
            end
            ism_pkg::S_SWAP_RD:  state_next = ism_pkg::S_SWAP_WR1;
            ism_pkg::S_SWAP_WR1: state_next = ism_pkg::S_SWAP_WR2;
            ism_pkg::S_SWAP_WR2: state_next = ism_pkg::S_NEXT_I;
            ism_pkg::S_NEXT_I:
            begin
                if (sort_more)
                    state_next = ism_pkg::S_SORT_RDI;
                else
                    state_next = ism_pkg::S_MRG_RD0;
            end
            ism_pkg::S_MRG_RD0:  state_next = ism_pkg::S_MRG_LD0;
            ism_pkg::S_MRG_LD0:
            begin
                if (count_reg == ism_pkg::cnt_t'(1))
                    state_next = ism_pkg::S_EMIT;
                else
                    state_next = ism_pkg::S_MRG_RD;
            end
            ism_pkg::S_MRG_RD:   state_next = ism_pkg::S_MRG_OVL;
            ism_pkg::S_MRG_OVL:
            begin
                // cur_e < begin: no overlap, emit the running interval
                if (cmp_lt)
                    state_next = ism_pkg::S_EMIT;
                else
                    state_next = ism_pkg::S_MRG_EXT;
            end
            ism_pkg::S_MRG_EXT:
            begin
                if (walk_more)
                    state_next = ism_pkg::S_MRG_RD;
                else
                    state_next = ism_pkg::S_EMIT;
            end
            ism_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    if (fin_flag_reg)
                        state_next = ism_pkg::S_LOAD;
                    else if (walk_more)
                        state_next = ism_pkg::S_MRG_RD;
                    else
                        state_next = ism_pkg::S_EMIT;
                end
            end
            default: state_next = ism_pkg::S_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready       = 1'b0;
        wr             = '0;
        raddr          = '0;
        cmp_a          = '0;
        cmp_b          = '0;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        i_next         = i_reg;
        j_next         = j_reg;
        pick_idx_next  = pick_idx_reg;
        pick_b_next    = pick_b_reg;
        start_i_next   = start_i_reg;
        fin_i_next     = fin_i_reg;
        fin_pick_next  = fin_pick_reg;
        k_next         = k_reg;
        cur_b_next     = cur_b_reg;
        cur_e_next     = cur_e_reg;
        nb_next        = nb_reg;
        ne_next        = ne_reg;
        fin_flag_next  = fin_flag_reg;
        out_b_next     = out_b_reg;
        out_e_next     = out_e_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;

        unique case (state_reg)
            ism_pkg::S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_xfer)
                begin
                    wr.we     = has_room;
                    wr.addr   = count_reg[ism_pkg::IDX_W-1:0];
                    wr.beg_ms = begin_ms;
                    wr.fin_ms = end_ms;
                    count_next = cnt_after;
                    if (!has_room)
                        ovf_next = 1'b1;
                    i_next        = '0;
                    fin_flag_next = 1'b0;
                end
            end
            ism_pkg::S_SORT_RDI:
            begin
                raddr = i_reg;
            end
            ism_pkg::S_SORT_LDI:
            begin
                pick_b_next   = rd_beg;
                start_i_next  = rd_beg;
                fin_i_next    = rd_fin;
                pick_idx_next = i_reg;
                j_next        = i_reg + ism_pkg::idx_t'(1);
            end
            ism_pkg::S_SCAN_RD:
            begin
                raddr = j_reg;
            end
            ism_pkg::S_SCAN_CMP:
            begin
                cmp_a = rd_beg;
                cmp_b = pick_b_reg;
                if (cmp_lt)
                begin
                    pick_idx_next = j_reg;
                    pick_b_next   = rd_beg;
                end
                if (scan_more)
                    j_next = j_reg + ism_pkg::idx_t'(1);
            end
            ism_pkg::S_SWAP_RD:
            begin
                raddr = pick_idx_reg;
            end
            ism_pkg::S_SWAP_WR1:
            begin
                fin_pick_next = rd_fin;
                wr.we     = 1'b1;
                wr.addr   = pick_idx_reg;
                wr.beg_ms = start_i_reg;
                wr.fin_ms = fin_i_reg;
            end
            ism_pkg::S_SWAP_WR2:
            begin
                wr.we     = 1'b1;
                wr.addr   = i_reg;
                wr.beg_ms = pick_b_reg;
                wr.fin_ms = fin_pick_reg;
            end
            ism_pkg::S_NEXT_I:
            begin
                i_next = i_reg + ism_pkg::idx_t'(1);
            end
            ism_pkg::S_MRG_RD0:
            begin
                raddr = '0;
            end
            ism_pkg::S_MRG_LD0:
            begin
                cur_b_next = rd_beg;
                cur_e_next = rd_fin;
                k_next     = ism_pkg::idx_t'(1);
                if (count_reg == ism_pkg::cnt_t'(1))
                    fin_flag_next = 1'b1;
            end
            ism_pkg::S_MRG_RD:
            begin
                raddr = k_reg;
            end
            ism_pkg::S_MRG_OVL:
            begin
                cmp_a   = cur_e_reg;
                cmp_b   = rd_beg;
                nb_next = rd_beg;
                ne_next = rd_fin;
            end
            ism_pkg::S_MRG_EXT:
            begin
                cmp_a = cur_e_reg;
                cmp_b = ne_reg;
                if (cmp_lt)
                    cur_e_next = ne_reg;
                if (walk_more)
                    k_next = k_reg + ism_pkg::idx_t'(1);
                else
                    fin_flag_next = 1'b1;
            end
            ism_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_b_next     = cur_b_reg;
                    out_e_next     = cur_e_reg;
                    out_last_next  = fin_flag_reg;
                    out_drop_next  = ovf_reg;
                    if (fin_flag_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        // start the next run from the interval that did not overlap
                        cur_b_next = nb_reg;
                        cur_e_next = ne_reg;
                        if (walk_more)
                            k_next = k_reg + ism_pkg::idx_t'(1);
                        else
                            fin_flag_next = 1'b1;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ism_pkg::S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            fin_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            fin_flag_reg  <= fin_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        pick_idx_reg <= pick_idx_next;
        pick_b_reg   <= pick_b_next;
        start_i_reg  <= start_i_next;
        fin_i_reg    <= fin_i_next;
        fin_pick_reg <= fin_pick_next;
        k_reg        <= k_next;
        cur_b_reg    <= cur_b_next;
        cur_e_reg    <= cur_e_next;
        nb_reg       <= nb_next;
        ne_reg       <= ne_next;
        out_b_reg    <= out_b_next;
        out_e_reg    <= out_e_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    assign out_valid       = out_valid_reg;
    assign merged_begin_ms = out_b_reg;
    assign merged_end_ms   = out_e_reg;
    assign last_result     = out_last_reg;
    assign dropped_flag    = out_drop_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ism_pkg::cnt_t'(ism_pkg::MAX_INTERVALS))
        else $error("held count above store depth");

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_item) |=> !in_ready)
        else $error("input still open after last interval");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ism_pkg::S_SCAN_CMP) |-> (j_reg > i_reg))
        else $error("scan index not past sort position");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ism_pkg::S_MRG_RD) |-> ({1'b0, k_reg} < count_reg))
        else $error("merge walk beyond held intervals");

endmodule

`default_nettype wire
